/* src/ctt_pkg.sv */
// Shared types, constants and helper functions for the configuration text tokenizer.
// Used by every module under src; depends on nothing.
`default_nettype none

package ctt_pkg;

   // Position counters and result fields
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

   // Result queue sizing
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_LEVEL_W = $clog2(FIFO_DEPTH + 1);

   // Stream widths: input tdata holds text_byte, tuser holds is_end
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELD_W = 3 + 8 + 2 * POS_BITS;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Token kinds
   localparam logic [2:0] KIND_NAME_BYTE = 3'd0;
   localparam logic [2:0] KIND_NAME_END  = 3'd1;
   localparam logic [2:0] KIND_SEMI      = 3'd2;
   localparam logic [2:0] KIND_OPEN      = 3'd3;
   localparam logic [2:0] KIND_CLOSE     = 3'd4;
   localparam logic [2:0] KIND_END       = 3'd5;

   // Lexer modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_NAME    = 2'd1;
   localparam logic [1:0] MODE_COMMENT = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_DASH    = 8'h2D;

   // One result item
   typedef struct packed {
      logic [2:0]          token_kind;
      logic [7:0]          name_byte;
      logic [POS_BITS-1:0] token_row;
      logic [POS_BITS-1:0] token_col;
      logic                last_of_run;
   } result_type;

   // Results produced by one input item, first one goes out first
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Letters, digits and the extra name punctuation
   function automatic logic is_name_char(input logic [7:0] c);
      logic hit;
      hit = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39) ||
            c == CH_DOLLAR || c == CH_UNDER || c == CH_DOT || c == CH_BSLASH ||
            c == CH_SLASH || c == CH_DQUOTE || c == CH_SQUOTE || c == CH_TILDE ||
            c == CH_DASH;
      return hit;
   endfunction

   function automatic result_type make_result(input logic [2:0] kind,
                                              input logic [7:0] nbyte,
                                              input logic [POS_BITS-1:0] row,
                                              input logic [POS_BITS-1:0] col);
      result_type r;
      r.token_kind  = kind;
      r.name_byte   = nbyte;
      r.token_row   = row;
      r.token_col   = col;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/config_text_tokenizer.sv */
// Configuration text tokenizer, top level: input stage, lexer core, result queue.
// Depends on ctt_pkg, ctt_lexer and ctt_result_fifo.
//
// Takes one text byte per transfer (req_tuser high marks end of input) and
// streams out tokens: each name byte, a name end after each name, braces,
// semicolons and an end-of-input token, each tagged with the row and column
// just after it. Comments from '#' to newline and all other bytes are dropped.
// A byte is registered, decoded combinationally, and its zero to two results go
// into an eight-entry result queue; with a ready consumer and room in the queue
// the block takes one byte every cycle and gives one result every cycle, and a
// byte that yields two results (a name end plus another token) leaves one queued.
// Input is taken while the queue has room for the byte in flight and the new
// one.
`default_nettype none

module config_text_tokenizer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [ctt_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] text_byte
   input  wire logic                             req_tuser,  // [0] is_end
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [2:0] token_kind, [10:3] name_byte, [26:11] token_row, [42:27] token_col,
   // [47:43] zero
   output logic [ctt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast   // last_of_run
);

   logic                               stage_valid_ff, stage_valid_in;
   logic [7:0]                         stage_byte_ff;
   logic                               stage_end_ff;
   logic [ctt_pkg::FIFO_LEVEL_W-1:0]   level;
   logic [ctt_pkg::FIFO_LEVEL_W:0]     reserved;
   logic                               req_xfer;
   ctt_pkg::push_type                  results;
   ctt_pkg::result_type                head;

   // Room check: queued results plus two for the byte in the stage
   assign reserved   = {1'b0, level} + (stage_valid_ff ? (ctt_pkg::FIFO_LEVEL_W + 1)'(2)
                                                       : '0);
   assign req_tready = reserved <= (ctt_pkg::FIFO_LEVEL_W + 1)'(ctt_pkg::FIFO_DEPTH - 2);
   assign req_xfer   = req_tvalid && req_tready;
   assign stage_valid_in = req_xfer;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_byte_ff <= req_tdata[7:0];
         stage_end_ff  <= req_tuser;
      end
   end

   ctt_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (stage_valid_ff),
      .item_byte  (stage_byte_ff),
      .item_end   (stage_end_ff),
      .results    (results)
   );

   ctt_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head),
      .level     (level)
   );

   // Pack the head result
   assign rsp_tdata = {(ctt_pkg::RSP_DATA_W - ctt_pkg::RSP_FIELD_W)'(0),
                       head.token_col, head.token_row, head.name_byte, head.token_kind};
   assign rsp_tlast = head.last_of_run;

endmodule

`default_nettype wire

/* src/ctt_lexer.sv */
// Tokenizer core: mode and position registers plus the per-byte decode.
// Depends on ctt_pkg.
`default_nettype none

module ctt_lexer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire logic [7:0]        item_byte,
   input  wire logic              item_end,
   output ctt_pkg::push_type      results
);

   logic [1:0]                   mode_ff, mode_in;
   logic [ctt_pkg::POS_BITS-1:0] row_ff, row_in;
   logic [ctt_pkg::POS_BITS-1:0] col_ff, col_in;
   logic                         finished_ff, finished_in;

   logic                         name_c;
   logic                         ended;
   logic                         has_tok;
   logic [2:0]                   tok_kind;
   logic [7:0]                   tok_byte;
   logic [ctt_pkg::POS_BITS-1:0] row_adv, col_adv;
   ctt_pkg::push_type            res;

   // Position after consuming the current byte, saturating
   always_comb begin
      if (item_byte == ctt_pkg::CH_NEWLINE) begin
         row_adv = (row_ff == ctt_pkg::POS_MAX) ? row_ff : row_ff + ctt_pkg::POS_ONE;
         col_adv = ctt_pkg::POS_ONE;
      end else begin
         row_adv = row_ff;
         col_adv = (col_ff == ctt_pkg::POS_MAX) ? col_ff : col_ff + ctt_pkg::POS_ONE;
      end
   end

   // Byte class and the token it gives on its own
   always_comb begin
      name_c   = ctt_pkg::is_name_char(item_byte);
      has_tok  = 1'b1;
      tok_kind = ctt_pkg::KIND_NAME_BYTE;
      tok_byte = 8'h00;
      if (name_c) begin
         tok_byte = item_byte;
      end else if (item_byte == ctt_pkg::CH_LBRACE) begin
         tok_kind = ctt_pkg::KIND_OPEN;
      end else if (item_byte == ctt_pkg::CH_RBRACE) begin
         tok_kind = ctt_pkg::KIND_CLOSE;
      end else if (item_byte == ctt_pkg::CH_SEMI) begin
         tok_kind = ctt_pkg::KIND_SEMI;
      end else begin
         has_tok = 1'b0;
      end
      ended = (mode_ff == ctt_pkg::MODE_NAME) && !name_c;
   end

   // Mode update and result assembly; mode code 3 behaves as idle
   always_comb begin
      mode_in     = mode_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      finished_in = finished_ff;
      res         = '0;
      if (item_valid) begin
         if (finished_ff) begin
            res.count = 2'd1;
            res.first = ctt_pkg::make_result(ctt_pkg::KIND_END, 8'h00, row_ff, col_ff);
         end else if (item_end) begin
            if (mode_ff == ctt_pkg::MODE_NAME) begin
               res.count  = 2'd2;
               res.first  = ctt_pkg::make_result(ctt_pkg::KIND_NAME_END, 8'h00,
                                                 row_ff, col_ff);
               res.second = ctt_pkg::make_result(ctt_pkg::KIND_END, 8'h00, row_ff, col_ff);
            end else begin
               res.count = 2'd1;
               res.first = ctt_pkg::make_result(ctt_pkg::KIND_END, 8'h00, row_ff, col_ff);
            end
            mode_in     = ctt_pkg::MODE_IDLE;
            finished_in = 1'b1;
         end else if (mode_ff == ctt_pkg::MODE_COMMENT) begin
            row_in = row_adv;
            col_in = col_adv;
            if (item_byte == ctt_pkg::CH_NEWLINE) begin
               mode_in = ctt_pkg::MODE_IDLE;
            end
         end else begin
            row_in = row_adv;
            col_in = col_adv;
            if (name_c) begin
               mode_in = ctt_pkg::MODE_NAME;
            end else if (item_byte == ctt_pkg::CH_HASH) begin
               mode_in = ctt_pkg::MODE_COMMENT;
            end else begin
               mode_in = ctt_pkg::MODE_IDLE;
            end
            // name end carries the position before the ending byte
            if (ended) begin
               res.first = ctt_pkg::make_result(ctt_pkg::KIND_NAME_END, 8'h00,
                                                row_ff, col_ff);
               if (has_tok) begin
                  res.count  = 2'd2;
                  res.second = ctt_pkg::make_result(tok_kind, tok_byte, row_adv, col_adv);
               end else begin
                  res.count = 2'd1;
               end
            end else if (has_tok) begin
               res.count = 2'd1;
               res.first = ctt_pkg::make_result(tok_kind, tok_byte, row_adv, col_adv);
            end
         end
         // flag the final result of this transfer
         if (res.count == 2'd1) begin
            res.first.last_of_run = 1'b1;
         end
         if (res.count == 2'd2) begin
            res.second.last_of_run = 1'b1;
         end
      end
   end

   assign results = res;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ctt_pkg::MODE_IDLE;
         row_ff      <= ctt_pkg::POS_ONE;
         col_ff      <= ctt_pkg::POS_ONE;
         finished_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         finished_ff <= finished_in;
      end
   end

   // Once finished, stays finished until reset
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("end-of-input flag dropped");

   // After the end, each item gives exactly one end result
   a_after_end: assert property (@(posedge clock) disable iff (reset)
      (item_valid && finished_ff) |->
         (res.count == 2'd1 && res.first.token_kind == ctt_pkg::KIND_END))
      else $error("item after end did not give a single end result");

   // A pair of results always starts with a name end
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (res.count == 2'd2) |-> (res.first.token_kind == ctt_pkg::KIND_NAME_END))
      else $error("two results without leading name end");

   // Position does not move once the input is finished
   a_pos_frozen: assert property (@(posedge clock) disable iff (reset)
      (finished_ff && $past(finished_ff)) |-> ($stable(row_ff) && $stable(col_ff)))
      else $error("position moved after end of input");

endmodule

`default_nettype wire

/* src/ctt_result_fifo.sv */
// Result queue: takes up to two results per cycle, sends one per transfer.
// Depends on ctt_pkg.
`default_nettype none

module ctt_result_fifo (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  ctt_pkg::push_type                       push,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output ctt_pkg::result_type                     out_data,
   output logic [ctt_pkg::FIFO_LEVEL_W-1:0]        level
);

   ctt_pkg::result_type                 mem_ff [ctt_pkg::FIFO_DEPTH];
   logic [ctt_pkg::FIFO_PTR_W-1:0]      wp_ff, wp_in;
   logic [ctt_pkg::FIFO_PTR_W-1:0]      rp_ff, rp_in;
   logic [ctt_pkg::FIFO_LEVEL_W-1:0]    count_ff, count_in;
   logic [ctt_pkg::FIFO_PTR_W-1:0]      wp_next;
   logic                                pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign level     = count_ff;
   assign wp_next   = wp_ff + ctt_pkg::FIFO_PTR_W'(1);

   // Pointer and fill updates
   always_comb begin
      wp_in    = wp_ff + ctt_pkg::FIFO_PTR_W'(push.count);
      rp_in    = pop ? rp_ff + ctt_pkg::FIFO_PTR_W'(1) : rp_ff;
      count_in = count_ff + ctt_pkg::FIFO_LEVEL_W'(push.count)
                 - ctt_pkg::FIFO_LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   // Storage, two write slots
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wp_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wp_next] <= push.second;
      end
   end

   // Never overfilled
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + (ctt_pkg::FIFO_LEVEL_W + 1)'(push.count))
         <= (ctt_pkg::FIFO_LEVEL_W + 1)'(ctt_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   // Fill level tracks the pointers
   a_level_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != (ctt_pkg::FIFO_LEVEL_W)'(ctt_pkg::FIFO_DEPTH)) |->
         (ctt_pkg::FIFO_PTR_W'(wp_ff - rp_ff) == ctt_pkg::FIFO_PTR_W'(count_ff)))
      else $error("fill level and pointers disagree");

   // Unpopped head holds its place
   a_head_stable: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (rp_ff == $past(rp_ff)))
      else $error("head moved without transfer");

endmodule

`default_nettype wire

/* tb/config_text_tokenizer_tb.sv */
// Self-checking testbench for config_text_tokenizer: streams text bytes in and checks
// every token against an in-bench lexer model. Depends on ctt_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module config_text_tokenizer_tb;

   localparam int QUIET_LIMIT = 2000;   // cycles without any transfer
   localparam int DRAIN_CYCLES = 16;
   localparam int ROW_LSB = 11;
   localparam int COL_LSB = ROW_LSB + ctt_pkg::POS_BITS;
   localparam int PAD_LSB = COL_LSB + ctt_pkg::POS_BITS;

   // one pending text transfer
   typedef struct packed {
      logic       is_end;
      logic [7:0] text_byte;
   } text_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ctt_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] text_byte
   logic req_tuser = 1'b0;                           // [0] is_end
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ctt_pkg::RSP_DATA_W-1:0] rsp_tdata;   // [2:0] kind, [10:3] byte, [26:11] row,
                                                // [42:27] col, [47:43] zero
   logic rsp_tlast;                             // last_of_run

   text_item_type       text_backlog[$];
   ctt_pkg::result_type tokens_due[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // lexer model state
   logic [1:0]                   lex_mode = ctt_pkg::MODE_IDLE;
   logic [ctt_pkg::POS_BITS-1:0] line_pos = ctt_pkg::POS_ONE;
   logic [ctt_pkg::POS_BITS-1:0] col_pos = ctt_pkg::POS_ONE;
   logic                         text_done = 1'b0;

   config_text_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // letters, digits and the name punctuation
   function automatic logic ident_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
             c == ctt_pkg::CH_DOLLAR || c == ctt_pkg::CH_UNDER || c == ctt_pkg::CH_DOT ||
             c == ctt_pkg::CH_BSLASH || c == ctt_pkg::CH_SLASH || c == ctt_pkg::CH_DQUOTE ||
             c == ctt_pkg::CH_SQUOTE || c == ctt_pkg::CH_TILDE || c == ctt_pkg::CH_DASH;
   endfunction

   function automatic ctt_pkg::result_type token_here(input logic [2:0] kind,
                                                      input logic [7:0] b);
      ctt_pkg::result_type t;
      t.token_kind  = kind;
      t.name_byte   = b;
      t.token_row   = line_pos;
      t.token_col   = col_pos;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   // consumed byte moves the position, both counters saturate
   task automatic step_position(input logic [7:0] c);
      if (c == ctt_pkg::CH_NEWLINE) begin
         if (line_pos != ctt_pkg::POS_MAX) line_pos = line_pos + 1'b1;
         col_pos = ctt_pkg::POS_ONE;
      end else if (col_pos != ctt_pkg::POS_MAX) begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   // work out the tokens one accepted text transfer causes
   task automatic predict_tokens(input logic [7:0] c, input logic end_mark);
      ctt_pkg::result_type outs[2];
      int n;
      n = 0;
      if (lex_mode != ctt_pkg::MODE_NAME && lex_mode != ctt_pkg::MODE_COMMENT)
         lex_mode = ctt_pkg::MODE_IDLE;
      if (text_done) begin
         outs[n] = token_here(ctt_pkg::KIND_END, 8'h00); n++;
      end else if (end_mark) begin
         if (lex_mode == ctt_pkg::MODE_NAME) begin
            outs[n] = token_here(ctt_pkg::KIND_NAME_END, 8'h00); n++;
         end
         outs[n] = token_here(ctt_pkg::KIND_END, 8'h00); n++;
         lex_mode = ctt_pkg::MODE_IDLE;
         text_done = 1'b1;
      end else if (lex_mode == ctt_pkg::MODE_COMMENT) begin
         step_position(c);
         if (c == ctt_pkg::CH_NEWLINE) lex_mode = ctt_pkg::MODE_IDLE;
      end else begin
         // name end carries the position before the ending byte
         if (lex_mode == ctt_pkg::MODE_NAME && !ident_char(c)) begin
            outs[n] = token_here(ctt_pkg::KIND_NAME_END, 8'h00); n++;
            lex_mode = ctt_pkg::MODE_IDLE;
         end
         step_position(c);
         if (ident_char(c)) begin
            lex_mode = ctt_pkg::MODE_NAME;
            outs[n] = token_here(ctt_pkg::KIND_NAME_BYTE, c); n++;
         end else if (c == ctt_pkg::CH_HASH) begin
            lex_mode = ctt_pkg::MODE_COMMENT;
         end else if (c == ctt_pkg::CH_LBRACE) begin
            outs[n] = token_here(ctt_pkg::KIND_OPEN, 8'h00); n++;
         end else if (c == ctt_pkg::CH_RBRACE) begin
            outs[n] = token_here(ctt_pkg::KIND_CLOSE, 8'h00); n++;
         end else if (c == ctt_pkg::CH_SEMI) begin
            outs[n] = token_here(ctt_pkg::KIND_SEMI, 8'h00); n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         outs[i].last_of_run = (i == n - 1);
         tokens_due.push_back(outs[i]);
      end
   endtask

   task automatic note_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // driver: offers the next backlog byte, idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_tokens(req_tdata, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (text_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               text_item_type nxt;
               nxt = text_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.text_byte;
               req_tuser  <= nxt.is_end;
            end else begin
               req_tvalid <= 1'b0;
               req_tdata  <= 8'($urandom_range(255));
               req_tuser  <= 1'($urandom_range(1));
            end
         end
      end
   end

   // monitor: checks each token transfer against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tokens_due.size() == 0) begin
               note_mismatch($sformatf("unexpected token tdata=%h tlast=%b",
                                       rsp_tdata, rsp_tlast));
            end else begin
               ctt_pkg::result_type want;
               want = tokens_due.pop_front();
               if (rsp_tdata[2:0] !== want.token_kind)
                  note_mismatch($sformatf("token_kind expected %0d got %0d",
                                          want.token_kind, rsp_tdata[2:0]));
               if (rsp_tdata[10:3] !== want.name_byte)
                  note_mismatch($sformatf("name_byte expected %h got %h",
                                          want.name_byte, rsp_tdata[10:3]));
               if (rsp_tdata[ROW_LSB +: ctt_pkg::POS_BITS] !== want.token_row)
                  note_mismatch($sformatf("token_row expected %0d got %0d",
                                          want.token_row,
                                          rsp_tdata[ROW_LSB +: ctt_pkg::POS_BITS]));
               if (rsp_tdata[COL_LSB +: ctt_pkg::POS_BITS] !== want.token_col)
                  note_mismatch($sformatf("token_col expected %0d got %0d",
                                          want.token_col,
                                          rsp_tdata[COL_LSB +: ctt_pkg::POS_BITS]));
               if (rsp_tdata[ctt_pkg::RSP_DATA_W-1:PAD_LSB] !== '0)
                  note_mismatch($sformatf("tdata padding not zero: %h", rsp_tdata));
               if (rsp_tlast !== want.last_of_run)
                  note_mismatch($sformatf("last_of_run expected %b got %b",
                                          want.last_of_run, rsp_tlast));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("config_text_tokenizer_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] c);
      text_backlog.push_back({1'b0, c});
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   function automatic logic [7:0] random_name_char();
      int r;
      r = $urandom_range(70);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      case (r - 62)
         0: return ctt_pkg::CH_DOLLAR;
         1: return ctt_pkg::CH_UNDER;
         2: return ctt_pkg::CH_DOT;
         3: return ctt_pkg::CH_BSLASH;
         4: return ctt_pkg::CH_SLASH;
         5: return ctt_pkg::CH_DQUOTE;
         6: return ctt_pkg::CH_SQUOTE;
         7: return ctt_pkg::CH_TILDE;
         default: return ctt_pkg::CH_DASH;
      endcase
   endfunction

   // one piece of plausible config text, sometimes noise or an open comment
   task automatic queue_random_piece();
      int pick;
      logic [7:0] c;
      pick = $urandom_range(99);
      if (pick < 40) begin
         repeat ($urandom_range(1, 8)) queue_byte(random_name_char());
      end else if (pick < 55) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(2))
               0: queue_byte(" ");
               1: queue_byte("\t");
               default: queue_byte("\r");
            endcase
         end
      end else if (pick < 62) begin
         queue_byte(ctt_pkg::CH_NEWLINE);
      end else if (pick < 80) begin
         case ($urandom_range(2))
            0: queue_byte(ctt_pkg::CH_LBRACE);
            1: queue_byte(ctt_pkg::CH_RBRACE);
            default: queue_byte(ctt_pkg::CH_SEMI);
         endcase
      end else if (pick < 90) begin
         queue_byte(ctt_pkg::CH_HASH);
         repeat ($urandom_range(6)) begin
            c = 8'($urandom_range(255));
            queue_byte(c == ctt_pkg::CH_NEWLINE ? ctt_pkg::CH_RBRACE : c);
         end
         // an unterminated comment now and then swallows what follows
         if ($urandom_range(9) != 0) queue_byte(ctt_pkg::CH_NEWLINE);
      end else begin
         queue_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic wait_backlog_empty();
      while (text_backlog.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      int target;
      wait_backlog_empty();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      target = text_backlog.size() + count;
      while (text_backlog.size() < target) queue_random_piece();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, name ended by a brace, by a comment and by a
      // newline, tokens and a hash inside a comment, stray high bytes
      queue_byte(8'h00);
      queue_text("A9~{x#};{");
      queue_byte(8'hFF);
      queue_byte(ctt_pkg::CH_HASH);
      queue_byte(ctt_pkg::CH_NEWLINE);
      queue_text("}q;");
      queue_byte(8'h80);
      queue_text("-\n");

      // random text under the four flow-control mixes
      run_phase(0, 0, 472);
      run_phase(72, 0, 472);
      run_phase(0, 72, 472);
      run_phase(8, 8, 472);

      // leave any open comment, then stop inside a name
      queue_byte(ctt_pkg::CH_NEWLINE);
      queue_text("c}de");

      // end of input inside a name, then input after the end
      text_backlog.push_back({1'b1, 8'($urandom_range(255))});
      repeat (40) text_backlog.push_back({1'($urandom_range(1)), 8'($urandom_range(255))});
      run_phase(8, 8, 0);

      while (text_backlog.size() != 0 || req_tvalid || tokens_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && tokens_due.size() == 0) begin
         $display("config_text_tokenizer_tb: clean");
      end else begin
         $display("config_text_tokenizer_tb: errors");
      end
      $finish;
   end

endmodule
